FILE: hw/rtl/mrx_pkg.sv
package mrx_pkg;

    localparam int RX_BUFFER_DEPTH_DEF = 64;
    localparam logic [15:0] GAP_TICKS_RESET = 16'd5;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_GOOD = 16'h0000;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] GAP_MAX = 16'hFFFF;
    localparam int MAX_SHOWN = 62;

    localparam logic [1:0] FUNC_BYTE = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;

    localparam logic [1:0] KIND_OK = 2'd0;
    localparam logic [1:0] KIND_CRC_ERR = 2'd1;
    localparam logic [1:0] KIND_RUNT = 2'd2;
    localparam logic [1:0] KIND_DATA = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] addr;
        logic [7:0] func;
        logic [5:0] len;
        logic [5:0] shown;
    } mrx_job_t;

    // CRC-16/MODBUS lookup entry for one index byte
    function automatic logic [15:0] crc16_tab(input logic [7:0] idx);
        logic [15:0] c;
        c = {8'h00, idx};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc,
                                               input logic [7:0] data);
        return {8'h00, crc[15:8]} ^ crc16_tab(crc[7:0] ^ data);
    endfunction

endpackage

FILE: hw/rtl/mrx_front.sv
module mrx_front import mrx_pkg::*; #(
    parameter int RX_BUFFER_DEPTH = RX_BUFFER_DEPTH_DEF,
    localparam int AW = $clog2(RX_BUFFER_DEPTH),
    localparam int CW = $clog2(RX_BUFFER_DEPTH + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data,
    input  logic          busy,
    input  logic          q_full,
    output logic          q_push,
    output mrx_job_t      q_job,
    output logic          buf_we,
    output logic [AW-1:0] buf_waddr,
    output logic [7:0]    buf_wdata
);

    localparam logic [1:0] PH_ADDR = 2'd0;
    localparam logic [1:0] PH_FUNC = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;

    logic [1:0]    phase_reg, phase_next;
    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    addr_reg, addr_next;
    logic [7:0]    func_reg, func_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pending_reg, pending_next;
    logic [15:0]   gap_reg, gap_next;
    logic          armed_reg, armed_next;
    logic [15:0]   gap_ticks_reg;

    logic          accept;
    logic [CW-1:0] count_sat;
    logic [CW-1:0] len;
    logic [15:0]   gap_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full && !((s_tuser == FUNC_BYTE) && busy);
    assign accept    = s_tvalid && s_tready;

    assign count_sat = (count_reg >= CW'(RX_BUFFER_DEPTH)) ?
                       CW'(RX_BUFFER_DEPTH - 1) : count_reg;
    assign len       = count_reg - CW'(2);
    assign gap_inc   = (gap_reg == GAP_MAX) ? gap_reg : gap_reg + 16'd1;

    assign buf_waddr = AW'(count_sat);
    assign buf_wdata = s_tdata;
    assign buf_we    = accept && (s_tuser == FUNC_BYTE) && !pending_reg &&
                       (phase_reg == PH_DATA);

    always_comb
    begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        addr_next    = addr_reg;
        func_next    = func_reg;
        count_next   = count_reg;
        pending_next = pending_reg;
        gap_next     = gap_reg;
        armed_next   = armed_reg;
        q_push       = 1'b0;
        q_job.kind   = KIND_OK;
        q_job.addr   = addr_reg;
        q_job.func   = func_reg;
        q_job.len    = 6'd0;
        q_job.shown  = 6'd0;
        if (accept)
        begin
            unique case (s_tuser)
                FUNC_BYTE:
                begin
                    if (!pending_reg)
                    begin
                        unique case (phase_reg)
                            PH_ADDR:
                            begin
                                addr_next  = s_tdata;
                                count_next = '0;
                                phase_next = PH_FUNC;
                                crc_next   = crc16_step(CRC_INIT, s_tdata);
                            end
                            PH_FUNC:
                            begin
                                func_next  = s_tdata;
                                phase_next = PH_DATA;
                                crc_next   = crc16_step(crc_reg, s_tdata);
                            end
                            default:
                            begin
                                count_next = count_sat + CW'(1);
                                crc_next   = crc16_step(crc_reg, s_tdata);
                            end
                        endcase
                        armed_next = 1'b1;
                        gap_next   = 16'd0;
                    end
                end
                FUNC_TICK:
                begin
                    gap_next = gap_inc;
                    if (armed_reg && (gap_inc >= gap_ticks_reg))
                    begin
                        q_push = 1'b1;
                        if ((phase_reg != PH_DATA) || (count_reg < CW'(2)))
                        begin
                            q_job.kind = KIND_RUNT;
                        end
                        else if (crc_reg != CRC_GOOD)
                        begin
                            q_job.kind = KIND_CRC_ERR;
                        end
                        else
                        begin
                            q_job.kind   = KIND_OK;
                            q_job.len    = 6'(len);
                            q_job.shown  = (32'(len) > 32'(MAX_SHOWN)) ?
                                           6'(MAX_SHOWN) : 6'(len);
                            count_next   = len;
                            pending_next = 1'b1;
                        end
                        crc_next   = CRC_INIT;
                        phase_next = PH_ADDR;
                        armed_next = 1'b0;
                    end
                end
                FUNC_RELEASE:
                begin
                    pending_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ADDR;
            crc_reg       <= CRC_INIT;
            addr_reg      <= 8'd0;
            func_reg      <= 8'd0;
            count_reg     <= '0;
            pending_reg   <= 1'b0;
            gap_reg       <= 16'd0;
            armed_reg     <= 1'b0;
            gap_ticks_reg <= GAP_TICKS_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            addr_reg    <= addr_next;
            func_reg    <= func_next;
            count_reg   <= count_next;
            pending_reg <= pending_next;
            gap_reg     <= gap_next;
            armed_reg   <= armed_next;
            if (cfg_valid && cfg_ready)
            begin
                gap_ticks_reg <= cfg_data;
            end
        end
    end

endmodule

FILE: hw/rtl/mrx_jobq.sv
module mrx_jobq import mrx_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mrx_job_t din,
    input  logic     pop,
    output mrx_job_t dout,
    output logic     full,
    output logic     empty
);

    mrx_job_t   slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;

    assign full  = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign dout  = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hw/rtl/mrx_back.sv
module mrx_back import mrx_pkg::*; #(
    parameter int RX_BUFFER_DEPTH = RX_BUFFER_DEPTH_DEF,
    localparam int AW = $clog2(RX_BUFFER_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  mrx_job_t      q_job,
    output logic          q_pop,
    output logic          busy,
    input  logic          buf_we,
    input  logic [AW-1:0] buf_waddr,
    input  logic [7:0]    buf_wdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,
    output logic [1:0]    m_tuser,
    output logic          m_tlast
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [7:0] mem [RX_BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    logic [1:0] state_reg, state_next;
    logic [5:0] idx_reg, idx_next;
    mrx_job_t   job_reg;
    logic       vld_reg, vld_next;
    logic       load_hdr, load_data;
    logic       out_free;
    logic       data_last;

    logic [1:0] o_kind_reg;
    logic [7:0] o_addr_reg, o_func_reg, o_byte_reg;
    logic [5:0] o_len_reg, o_idx_reg;
    logic       o_last_reg;

    assign out_free  = !vld_reg || m_tready;
    assign busy      = !q_empty || (state_reg != S_IDLE);
    assign data_last = ((idx_reg + 6'd1) == job_reg.shown);

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            mem[buf_waddr] <= buf_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[AW'(idx_reg)];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        vld_next   = vld_reg && !m_tready;
        load_hdr   = 1'b0;
        load_data  = 1'b0;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty && out_free)
                begin
                    q_pop    = 1'b1;
                    load_hdr = 1'b1;
                    vld_next = 1'b1;
                    idx_next = 6'd0;
                    if ((q_job.kind == KIND_OK) && (q_job.shown != 6'd0))
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load_data = 1'b1;
                    vld_next  = 1'b1;
                    if (data_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_hdr)
        begin
            job_reg    <= q_job;
            o_kind_reg <= q_job.kind;
            o_addr_reg <= q_job.addr;
            o_func_reg <= q_job.func;
            o_len_reg  <= q_job.len;
            o_idx_reg  <= 6'd0;
            o_byte_reg <= 8'd0;
            o_last_reg <= (q_job.kind != KIND_OK) || (q_job.shown == 6'd0);
        end
        else if (load_data)
        begin
            o_kind_reg <= KIND_DATA;
            o_addr_reg <= job_reg.addr;
            o_func_reg <= job_reg.func;
            o_len_reg  <= job_reg.len;
            o_idx_reg  <= idx_reg;
            o_byte_reg <= rd_data_reg;
            o_last_reg <= data_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 6'd0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            vld_reg   <= vld_next;
        end
    end

    assign m_tvalid = vld_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {4'b0000, o_byte_reg, o_idx_reg, o_len_reg, o_func_reg, o_addr_reg};

endmodule

FILE: hw/rtl/modbus_rtu_frame_receiver_top.sv
// Input: one transaction per cycle; byte transactions stall while a result is queued
// or being read out, and all transactions stall while the job queue is full.
// A tick that ends a frame pushes a job to the job queue; the back end pops it and
// registers the first result. Readout: the read sequencer passes each payload
// result through READ and EMIT (registered buffer read); up to 63 results per frame.
// Reset: asynchronous, active low; control cleared, gap_ticks back to 5,
// frame buffer contents left as they are (no clearing pass).
module modbus_rtu_frame_receiver_top import mrx_pkg::*; #(
    parameter int RX_BUFFER_DEPTH = RX_BUFFER_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] slave_address, [15:8] function_code, [21:16] payload_length,
    // [27:22] payload_index, [35:28] payload_byte, [39:36] zero
    output logic [39:0] m_tdata,
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int AW = $clog2(RX_BUFFER_DEPTH);

    logic          busy;
    logic          q_full, q_empty, q_push, q_pop;
    mrx_job_t      push_job, head_job;
    logic          buf_we;
    logic [AW-1:0] buf_waddr;
    logic [7:0]    buf_wdata;

    mrx_front #(.RX_BUFFER_DEPTH(RX_BUFFER_DEPTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job),
        .buf_we    (buf_we),
        .buf_waddr (buf_waddr),
        .buf_wdata (buf_wdata)
    );

    mrx_jobq u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_job),
        .pop   (q_pop),
        .dout  (head_job),
        .full  (q_full),
        .empty (q_empty)
    );

    mrx_back #(.RX_BUFFER_DEPTH(RX_BUFFER_DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .busy      (busy),
        .buf_we    (buf_we),
        .buf_waddr (buf_waddr),
        .buf_wdata (buf_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: verif/tb_modbus_rtu_frame_receiver_top.sv
module tb_modbus_rtu_frame_receiver_top;
    import mrx_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT_UNITS = 40_000_000;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_FUNC,
        PH_DATA
    } rx_phase_e;

    typedef struct {
        logic [1:0]  kind;
        logic [39:0] data;
        logic        last;
    } rx_result_t;

    function automatic logic [15:0] modbus_crc(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    class rx_frame_scoreboard;
        logic [15:0] gap_ticks;
        rx_phase_e   phase;
        logic [15:0] crc;
        logic [7:0]  addr;
        logic [7:0]  fcode;
        int          stored;
        logic [7:0]  frame_buf [RX_BUFFER_DEPTH_DEF];
        bit          frame_pending;
        logic [15:0] gap_count;
        bit          gap_armed;
        rx_result_t  readout_q [$];
        int          failures;
        int          mismatches;

        function void reset_state();
            gap_ticks = GAP_TICKS_RESET;
            phase = PH_ADDR;
            crc = CRC_INIT;
            addr = 8'h00;
            fcode = 8'h00;
            stored = 0;
            frame_pending = 1'b0;
            gap_count = 16'h0000;
            gap_armed = 1'b0;
            failures = 0;
            mismatches = 0;
        endfunction

        function void push_result(input logic [1:0] kind, input logic [5:0] len,
                                  input logic [5:0] idx, input logic [7:0] b,
                                  input logic last);
            rx_result_t r;
            r.kind = kind;
            r.data = {4'h0, b, idx, len, fcode, addr};
            r.last = last;
            readout_q.push_back(r);
        endfunction

        function void close_frame();
            int len;
            int shown;
            if (phase != PH_DATA || stored < 2)
                push_result(KIND_RUNT, 6'd0, 6'd0, 8'h00, 1'b1);
            else if (crc != CRC_GOOD)
                push_result(KIND_CRC_ERR, 6'd0, 6'd0, 8'h00, 1'b1);
            else
            begin
                len = stored - 2;
                shown = (len > MAX_SHOWN) ? MAX_SHOWN : len;
                stored = len;
                frame_pending = 1'b1;
                push_result(KIND_OK, 6'(len), 6'd0, 8'h00, shown == 0);
                for (int i = 0; i < shown; i++)
                    push_result(KIND_DATA, 6'(len), 6'(i), frame_buf[i], i + 1 == shown);
            end
            crc = CRC_INIT;
            phase = PH_ADDR;
            gap_armed = 1'b0;
        endfunction

        function void take_item(input logic [1:0] f, input logic [7:0] b);
            case (f)
                FUNC_BYTE:
                begin
                    if (!frame_pending)
                    begin
                        if (phase == PH_ADDR)
                        begin
                            crc = CRC_INIT;
                            addr = b;
                            stored = 0;
                            phase = PH_FUNC;
                        end
                        else if (phase == PH_FUNC)
                        begin
                            fcode = b;
                            phase = PH_DATA;
                        end
                        else
                        begin
                            if (stored >= RX_BUFFER_DEPTH_DEF)
                                stored = RX_BUFFER_DEPTH_DEF - 1;
                            frame_buf[stored] = b;
                            stored++;
                        end
                        gap_armed = 1'b1;
                        gap_count = 16'h0000;
                        crc = modbus_crc(crc, b);
                    end
                end
                FUNC_TICK:
                begin
                    if (gap_count != GAP_MAX)
                        gap_count++;
                    if (gap_armed && gap_count >= gap_ticks)
                        close_frame();
                end
                FUNC_RELEASE:
                    frame_pending = 1'b0;
                default:
                    ;
            endcase
        endfunction

        function void check_result(input logic [1:0] kind, input logic [39:0] data,
                                   input logic last);
            rx_result_t e;
            if (readout_q.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result: kind %0d data %010h last %0d",
                             kind, data, last);
                mismatches++;
                return;
            end
            e = readout_q.pop_front();
            if (kind !== e.kind || data[7:0] !== e.data[7:0] || data[15:8] !== e.data[15:8]
                || data[21:16] !== e.data[21:16] || data[27:22] !== e.data[27:22]
                || data[35:28] !== e.data[35:28] || data[39:36] !== e.data[39:36]
                || last !== e.last)
            begin
                failures++;
                if (mismatches < 10)
                begin
                    $display("mismatch exp: kind %0d addr %02h func %02h len %0d idx %0d",
                             e.kind, e.data[7:0], e.data[15:8], e.data[21:16],
                             e.data[27:22]);
                    $display("              byte %02h last %0d", e.data[35:28], e.last);
                    $display("         act: kind %0d addr %02h func %02h len %0d idx %0d",
                             kind, data[7:0], data[15:8], data[21:16], data[27:22]);
                    $display("              byte %02h last %0d pad %h",
                             data[35:28], last, data[39:36]);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [1:0]  s_tuser = 2'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    rx_frame_scoreboard sb = new();
    bit idle_on = 1'b1;
    int hold_cycles = 0;
    int items_sent = 0;

    modbus_rtu_frame_receiver_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #(TIMEOUT_UNITS);
        $display("== FAIL ==");
        $finish;
    end

    // result side: check, then decide ready for the next cycle
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
                sb.check_result(m_tuser, m_tdata, m_tlast);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int payload_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(0, 8);
        else if (r < 95)
            return $urandom_range(9, 62);
        return $urandom_range(63, 75);
    endfunction

    task automatic send_item(input logic [1:0] f, input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= b;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        sb.take_item(f, b);
        items_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(FUNC_TICK, any_byte());
    endtask

    task automatic end_gap();
        send_ticks(sb.gap_ticks + $urandom_range(0, 2));
    endtask

    task automatic send_frame(input logic [7:0] a, input logic [7:0] fc, input int n,
                              input bit corrupt);
        logic [7:0]  frame_q [$];
        logic [15:0] crc;
        int          pos;
        int          max_mid;
        frame_q.push_back(a);
        frame_q.push_back(fc);
        repeat (n) frame_q.push_back(any_byte());
        crc = CRC_INIT;
        foreach (frame_q[i])
            crc = modbus_crc(crc, frame_q[i]);
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        if (corrupt)
        begin
            pos = $urandom_range(0, frame_q.size() - 1);
            frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
        end
        max_mid = (sb.gap_ticks > 4) ? 3 : int'(sb.gap_ticks) - 1;
        foreach (frame_q[i])
        begin
            if (i > 0 && max_mid > 0 && $urandom_range(0, 7) == 0)
                send_ticks($urandom_range(1, max_mid));
            send_item(FUNC_BYTE, frame_q[i]);
        end
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.readout_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gap(input logic [15:0] v);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.gap_ticks = v;
    endtask

    task automatic random_traffic(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (sb.frame_pending && (pick < 72 || $urandom_range(0, 3) != 0))
                send_item(FUNC_RELEASE, any_byte());
            if (pick < 60)
            begin
                send_frame(any_byte(), any_byte(), payload_size(), 1'b0);
                end_gap();
                if ($urandom_range(0, 3) == 0)
                    send_item(FUNC_BYTE, any_byte());
                if ($urandom_range(0, 4) != 0)
                    send_item(FUNC_RELEASE, any_byte());
            end
            else if (pick < 72)
            begin
                send_frame(any_byte(), any_byte(), payload_size(), 1'b1);
                end_gap();
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(1, 3)) send_item(FUNC_BYTE, any_byte());
                end_gap();
            end
            else if (pick < 88)
                send_item($urandom_range(0, 1) ? FUNC_RELEASE : FUNC_UNUSED, any_byte());
            else if (pick < 94)
                send_ticks($urandom_range(1, 8));
            else
            begin
                repeat ($urandom_range(1, 6)) send_item(FUNC_BYTE, any_byte());
                end_gap();
            end
        end
    endtask

    initial
    begin
        sb.reset_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FUNC_RELEASE, 8'h00);
        send_item(FUNC_UNUSED, 8'hFF);
        // address only
        send_item(FUNC_BYTE, 8'h00);
        send_ticks(5);
        // one stored byte, ends exactly at the threshold
        send_item(FUNC_BYTE, 8'hFF);
        send_item(FUNC_BYTE, 8'h00);
        send_item(FUNC_BYTE, 8'hA5);
        send_ticks(4);
        send_item(FUNC_TICK, 8'h00);
        // empty payload, then byte while pending
        send_frame(8'h11, 8'h03, 0, 1'b0);
        send_ticks(5);
        send_item(FUNC_BYTE, 8'h55);
        send_item(FUNC_RELEASE, 8'hFF);
        send_frame(8'hFF, 8'hFF, 1, 1'b1);
        send_ticks(5);
        send_frame(8'h00, 8'h00, 2, 1'b0);
        send_ticks(5);
        send_item(FUNC_RELEASE, 8'h00);

        write_gap(16'd1);
        random_traffic(90);

        // largest threshold keeps the frame open; a small one then closes it
        write_gap(GAP_MAX);
        send_frame(8'h01, 8'h10, 4, 1'b0);
        send_ticks(20);
        write_gap(16'd2);
        send_item(FUNC_TICK, any_byte());
        send_item(FUNC_RELEASE, any_byte());

        write_gap(16'($urandom_range(2, 12)));
        random_traffic(60);

        // backpressure: output held off while input keeps coming
        wait_drain();
        hold_cycles = 400;
        send_frame(any_byte(), any_byte(), 40, 1'b0);
        send_ticks(sb.gap_ticks);
        send_item(FUNC_RELEASE, any_byte());
        send_frame(any_byte(), any_byte(), 12, 1'b0);
        send_ticks(sb.gap_ticks);
        send_item(FUNC_RELEASE, any_byte());
        wait_drain();

        write_gap(16'($urandom_range(2, 12)));
        random_traffic(70);

        write_gap(16'd3);
        idle_on = 1'b0;
        random_traffic(60);
        wait_drain();

        if (sb.failures == 0 && sb.readout_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: modbus_rtu_frame_receiver_top.f
hw/rtl/mrx_pkg.sv
hw/rtl/mrx_front.sv
hw/rtl/mrx_jobq.sv
hw/rtl/mrx_back.sv
hw/rtl/modbus_rtu_frame_receiver_top.sv
verif/tb_modbus_rtu_frame_receiver_top.sv
